>>> hdl/sse_pkg.sv
// shared types and codes of the sorted set engine
package sse_pkg;

	// action codes of a request item
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;

	// request item
	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
	} req_t;

	// response item
	typedef struct packed {
		logic       success;
		logic       set_full;
		logic [4:0] element_total;
		logic       set_empty;
	} rsp_t;

	// result of the shared compare unit
	typedef struct packed {
		logic eq;
		logic in_order;
	} cmp_res_t;

endpackage

>>> hdl/sse_mem.sv
// value store: one write port, one read port with registered read data
module sse_mem import sse_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic signed [31:0]  wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [31:0]  rd_data
);

	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/sse_cmp.sv
// shared compare unit: equality and order test of a stored entry against the key
module sse_cmp import sse_pkg::*; (
	input  logic signed [31:0] entry,
	input  logic signed [31:0] key,
	input  logic               descending,
	output cmp_res_t           res
);

	// entry may stand at or before key in the current order
	always_comb begin
		res.eq       = (entry == key);
		res.in_order = descending ? (entry >= key) : (entry <= key);
	end

endmodule

>>> hdl/sorted_set_engine_top.sv
// top level of the sorted set engine: sequencer, count and response register
//
//  channel | signals                    | item
//  --------+----------------------------+-----------------------------------
//  req     | req_valid req_ready req    | action and value
//  rsp     | rsp_valid rsp_ready rsp    | success, full, count, empty flag
//  cfg     | cfg_valid cfg_ready cfg_data | order bit (1 = descending)
//
// an item is accepted, then scanned one live entry per cycle through the compare
// unit, then decided; an add or remove moves entries by a read then a write on the
// single store port pair, an add that moves entries ends with an insert step (an
// append is written in the decision state), and the response register is loaded last.
// req_ready is high only while the sequencer is idle; a full response
// register stalls the sequencer in its last state. No clearing pass after reset.
module sorted_set_engine_top import sse_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_DECIDE = 4'd2;
	localparam logic [3:0] ST_UP_RD  = 4'd3;
	localparam logic [3:0] ST_UP_WR  = 4'd4;
	localparam logic [3:0] ST_DN_RD  = 4'd5;
	localparam logic [3:0] ST_DN_WR  = 4'd6;
	localparam logic [3:0] ST_DONE   = 4'd7;
	localparam logic [3:0] ST_INSERT = 4'd8;

	logic [3:0]         state_q;
	logic [CW-1:0]      count_q;
	logic               order_q;
	logic [1:0]         action_q;
	logic signed [31:0] value_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      ins_pos_q;
	logic [AW-1:0]      hit_idx_q;
	logic               found_q;
	logic               pos_found_q;
	logic               succ_q;
	logic               full_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_data;
	cmp_res_t           cmp;
	logic               req_acc;
	logic               scan_last;
	logic               dn_more;
	logic               dn_first;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// scan and shift boundaries
	assign scan_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign dn_first  = (((CW+1)'(hit_idx_q) + (CW+1)'(1)) < (CW+1)'(count_q));
	assign dn_more   = (((CW+1)'(j_q) + (CW+1)'(2)) < (CW+1)'(count_q));

	sse_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	sse_cmp u_cmp (
		.entry     (rd_data),
		.key       (value_q),
		.descending(order_q),
		.res       (cmp)
	);

	// store port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = j_q;
		wr_data = rd_data;
		case (state_q)
			ST_IDLE: begin
				rd_en   = req_acc;
				rd_addr = '0;
			end
			ST_SCAN: begin
				rd_en   = !scan_last;
				rd_addr = AW'(idx_q + 1'b1);
			end
			ST_DECIDE: begin
				if (action_q == ACT_ADD && !found_q && count_q < CW'(CAPACITY)
						&& CW'(ins_pos_q) == count_q) begin
					wr_en   = 1'b1;
					wr_addr = ins_pos_q;
					wr_data = value_q;
				end
			end
			ST_UP_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(j_q - 1'b1);
			end
			ST_UP_WR: begin
				wr_en = 1'b1;
			end
			ST_DN_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(j_q + 1'b1);
			end
			ST_DN_WR: begin
				wr_en = 1'b1;
			end
			ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = ins_pos_q;
				wr_data = value_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			pos_found_q <= 1'b0;
			succ_q      <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						action_q    <= req.action;
						value_q     <= req.value;
						idx_q       <= '0;
						found_q     <= 1'b0;
						pos_found_q <= 1'b0;
						ins_pos_q   <= AW'(count_q);
						hit_idx_q   <= '0;
						state_q     <= (count_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// one live entry per cycle through the compare unit
					if (cmp.eq && !found_q) begin
						found_q   <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!cmp.in_order && !pos_found_q) begin
						pos_found_q <= 1'b1;
						ins_pos_q   <= idx_q;
					end
					idx_q <= AW'(idx_q + 1'b1);
					if (scan_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					case (action_q)
						ACT_ADD: begin
							if (found_q) begin
								succ_q  <= 1'b0;
								full_q  <= 1'b0;
								state_q <= ST_DONE;
							end else if (count_q >= CW'(CAPACITY)) begin
								succ_q  <= 1'b0;
								full_q  <= 1'b1;
								state_q <= ST_DONE;
							end else if (CW'(ins_pos_q) == count_q) begin
								// appended at the end, written this cycle
								count_q <= count_q + 1'b1;
								succ_q  <= 1'b1;
								full_q  <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								j_q     <= AW'(count_q);
								state_q <= ST_UP_RD;
							end
						end
						ACT_REMOVE: begin
							if (found_q && dn_first) begin
								j_q     <= hit_idx_q;
								state_q <= ST_DN_RD;
							end else if (found_q) begin
								count_q <= count_q - 1'b1;
								succ_q  <= 1'b1;
								full_q  <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								succ_q  <= 1'b0;
								full_q  <= 1'b0;
								state_q <= ST_DONE;
							end
						end
						ACT_SEARCH: begin
							succ_q  <= found_q;
							full_q  <= 1'b0;
							state_q <= ST_DONE;
						end
						default: begin
							succ_q  <= 1'b0;
							full_q  <= 1'b0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_UP_RD: begin
					state_q <= ST_UP_WR;
				end
				ST_UP_WR: begin
					// entry j-1 moved up to j
					j_q <= AW'(j_q - 1'b1);
					if (AW'(j_q - 1'b1) == ins_pos_q) begin
						state_q <= ST_INSERT;
					end else begin
						state_q <= ST_UP_RD;
					end
				end
				ST_INSERT: begin
					// new value written into the opened slot
					count_q <= count_q + 1'b1;
					succ_q  <= 1'b1;
					full_q  <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DN_RD: begin
					state_q <= ST_DN_WR;
				end
				ST_DN_WR: begin
					// entry j+1 moved down to j
					j_q <= AW'(j_q + 1'b1);
					if (dn_more) begin
						state_q <= ST_DN_RD;
					end else begin
						count_q <= count_q - 1'b1;
						succ_q  <= 1'b1;
						full_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// load the response register once it is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.success       <= succ_q;
						rsp_q.set_full      <= full_q;
						rsp_q.element_total <= 5'(count_q);
						rsp_q.set_empty     <= (count_q == '0);
						rsp_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/sv/sorted_set_tracker_pkg.sv
// scoreboard class that predicts and checks sorted set engine responses
`timescale 1ns / 1ps
package sorted_set_tracker_pkg;
	import sse_pkg::*;

	// capacity of the engine under test
	localparam int SET_CAPACITY = 16;

	// action code that the engine treats as a no-op
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	class sorted_set_tracker;
		logic signed [31:0] members[SET_CAPACITY];
		int unsigned member_count;
		bit descending;
		rsp_t awaited[$];
		int unsigned fail_count;

		function new();
			member_count = 0;
			descending = 1'b0;
			fail_count = 0;
		endfunction

		function void set_order(bit desc);
			descending = desc;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// true when a may stand at or before b in the current order
		function bit precedes(logic signed [31:0] a, logic signed [31:0] b);
			return descending ? (a >= b) : (a <= b);
		endfunction

		// apply one accepted request item and queue the response it must cause
		function void accept_request(req_t item);
			logic signed [31:0] v;
			int unsigned hit;
			int unsigned slot;
			bit present;
			rsp_t outcome;
			v = item.value;
			hit = member_count;
			present = 1'b0;
			outcome = '0;
			// lookup compares against every live entry, order does not matter
			for (int unsigned i = 0; i < member_count; i++) begin
				if (!present && members[i] == v) begin
					hit = i;
					present = 1'b1;
				end
			end
			case (item.action)
				ACT_ADD: begin
					if (!present) begin
						if (member_count >= SET_CAPACITY) begin
							outcome.set_full = 1'b1;
						end else begin
							// insert before the first entry not placed at or before v
							slot = 0;
							while (slot < member_count && precedes(members[slot], v))
								slot++;
							for (int unsigned i = member_count; i > slot; i--)
								members[i] = members[i - 1];
							members[slot] = v;
							member_count++;
							outcome.success = 1'b1;
						end
					end
				end
				ACT_REMOVE: begin
					if (present) begin
						for (int unsigned i = hit; i + 1 < member_count; i++)
							members[i] = members[i + 1];
						member_count--;
						outcome.success = 1'b1;
					end
				end
				ACT_SEARCH: begin
					outcome.success = present;
				end
				default: begin
				end
			endcase
			outcome.element_total = 5'(member_count);
			outcome.set_empty = (member_count == 0);
			awaited.push_back(outcome);
		endfunction

		// compare one accepted response item with the oldest prediction
		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("response item with no prediction waiting: %p", got);
				fail_count++;
				return;
			end
			want = awaited.pop_front();
			if (got.success !== want.success) begin
				$error("success: expected %0d, got %0d", want.success, got.success);
				fail_count++;
			end
			if (got.set_full !== want.set_full) begin
				$error("set_full: expected %0d, got %0d", want.set_full, got.set_full);
				fail_count++;
			end
			if (got.element_total !== want.element_total) begin
				$error("element_total: expected %0d, got %0d",
					want.element_total, got.element_total);
				fail_count++;
			end
			if (got.set_empty !== want.set_empty) begin
				$error("set_empty: expected %0d, got %0d", want.set_empty, got.set_empty);
				fail_count++;
			end
		endfunction
	endclass

endpackage

>>> tb/sv/sorted_set_engine_top_tb.sv
// testbench of the sorted set engine: directed and random request items
`timescale 1ns / 1ps
module sorted_set_engine_top_tb;
	import sse_pkg::*;
	import sorted_set_tracker_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE = 24;
	localparam int BLOCK_COUNT = 7;
	localparam int BLOCK_ITEMS = 100;
	localparam int SETTLE_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	req_t req = '0;
	logic rsp_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_data = 1'b0;
	logic req_ready;
	logic rsp_valid;
	logic cfg_ready;
	rsp_t rsp;

	sorted_set_tracker tracker;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 21;
	int unsigned receiver_idle_pct = 52;
	logic signed [31:0] value_pool[POOL_SIZE];

	sorted_set_engine_top #(.CAPACITY(SET_CAPACITY)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		if (arst_n)
			rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// check every accepted response item
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(rsp);
	end

	task automatic wait_all_results();
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// drop valid and hold off until every predicted response has arrived
	task automatic pause_requests();
		@(negedge clk);
		req_valid <= 1'b0;
		wait_all_results();
	endtask

	task automatic write_order(bit desc);
		pause_requests();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= desc;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_order(desc);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one request item, with a random gap before it
	task automatic send_request(logic [1:0] act, logic signed [31:0] val);
		req_t item;
		item.action = act;
		item.value = val;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		tracker.accept_request(item);
	endtask

	// mostly values from a small pool so that hits are common
	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(99) < 75)
			return value_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_action(int unsigned add_weight);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return ACT_UNUSED;
		if (r < 3 + add_weight)
			return ACT_ADD;
		if (r < 3 + add_weight + (97 - add_weight) * 3 / 5)
			return ACT_REMOVE;
		return ACT_SEARCH;
	endfunction

	initial begin
		int unsigned add_weight;
		logic signed [31:0] fill_value;
		tracker = new();
		value_pool[0] = 32'sh7FFFFFFF;
		value_pool[1] = 32'sh80000000;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		// reset
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty set, extremes, duplicates, absent values, no-op
		write_order(1'b0);
		send_request(ACT_SEARCH, 32'sd0);
		send_request(ACT_REMOVE, 32'sd5);
		send_request(ACT_UNUSED, -32'sd1);
		send_request(ACT_ADD, 32'sh7FFFFFFF);
		send_request(ACT_ADD, 32'sh80000000);
		send_request(ACT_ADD, 32'sh80000000);
		send_request(ACT_SEARCH, 32'sh7FFFFFFF);
		send_request(ACT_REMOVE, 32'sh7FFFFFFF);
		send_request(ACT_REMOVE, 32'sh7FFFFFFF);
		// fill to capacity, then a present and an absent add on a full set
		for (int k = 1; k < SET_CAPACITY; k++) begin
			fill_value = (k % 2) ? -(k * 1000003) : (k * 7777777);
			send_request(ACT_ADD, fill_value);
		end
		send_request(ACT_ADD, 32'sh80000000);
		send_request(ACT_ADD, 32'sd12345);
		// order flipped on a full set: entries keep their old order
		write_order(1'b1);

		// random blocks: add-heavy, with every third block remove-heavy
		for (int b = 0; b < BLOCK_COUNT; b++) begin
			if (b < 2) begin
				sender_idle_pct = 21;
				receiver_idle_pct = 52;
			end else if (b < 4) begin
				sender_idle_pct = 52;
				receiver_idle_pct = 21;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_order(b % 2 == 0);
			add_weight = (b % 3 == 2) ? 25 : 60;
			for (int i = 0; i < 4; i++)
				value_pool[4 + $urandom_range(POOL_SIZE - 5)] = $urandom;
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				send_request(pick_action(add_weight), pick_value());
				if ($urandom_range(49) == 0)
					pause_requests();
			end
		end

		// drain and settle
		pause_requests();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.fail_count == 0 && tracker.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
hdl/sse_pkg.sv
hdl/sse_mem.sv
hdl/sse_cmp.sv
hdl/sorted_set_engine_top.sv
tb/sv/sorted_set_tracker_pkg.sv
tb/sv/sorted_set_engine_top_tb.sv
